/* rtl/fmv_pkg.sv */
// Shared types, constants and tag lookup functions for the FIX message validator.
package fmv_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int ACC_W       = VALUE_BITS - 1;  // largest good value is all ones
  localparam int TAG_W       = 31;              // largest tag is 2^31-1, all ones
  localparam int OUT_W       = 31;
  localparam int NUM_TRACKED = 14;
  localparam int NUM_NUMERIC = 5;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [ACC_W-1:0] value_t;
  typedef logic [OUT_W-1:0] out_value_t;
  typedef logic [NUM_TRACKED-1:0] seen_t;

  // Positions in the tracked tag list
  localparam int BIT_TYPE  = 2;
  localparam int BIT_HB    = 12;
  localparam int BIT_PRICE = 13;

  // Positions in the numeric store
  localparam int SLOT_HB    = 0;
  localparam int SLOT_SIDE  = 1;
  localparam int SLOT_KIND  = 2;
  localparam int SLOT_PRICE = 3;
  localparam int SLOT_QTY   = 4;

  localparam seen_t HEADER_MASK = 14'h007F;
  localparam seen_t ORDER_MASK  = 14'h0F80;

  localparam tag_t TRACKED_TAGS [NUM_TRACKED] = '{
    31'd8, 31'd9, 31'd35, 31'd34, 31'd49, 31'd56, 31'd10,
    31'd11, 31'd55, 31'd54, 31'd38, 31'd40, 31'd108, 31'd44
  };
  localparam tag_t NUMERIC_TAGS [NUM_NUMERIC] = '{
    31'd108, 31'd54, 31'd40, 31'd44, 31'd38
  };
  localparam tag_t TAG_MSG_TYPE = 31'd35;

  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] TYPE_LOGON     = 8'h41;
  localparam logic [7:0] TYPE_NEW_ORDER = 8'h44;

  localparam value_t VAL_ONE = value_t'(1);
  localparam value_t VAL_TWO = value_t'(2);

  localparam logic [7:0] DELIM_RESET = 8'h01;

  typedef enum logic [3:0] {
    V_OK          = 4'd0,
    V_MALFORMED   = 4'd1,
    V_NO_HEADER   = 4'd2,
    V_NO_HB       = 4'd3,
    V_BAD_HB      = 4'd4,
    V_NO_ORDER    = 4'd5,
    V_BAD_SIDE    = 4'd6,
    V_BAD_KIND    = 4'd7,
    V_NO_PRICE    = 4'd8,
    V_BAD_PRICE   = 4'd9,
    V_BAD_QTY     = 4'd10,
    V_UNSUPPORTED = 4'd11
  } verdict_t;

  typedef enum logic [1:0] {
    PH_BLANK   = 2'd0,
    PH_SIGN    = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  typedef struct packed {
    logic   bad;
    logic   neg;
    phase_t phase;
  } value_status_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } tag_hit_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } slot_hit_t;

  // Final message state handed from the parser to the verdict stage
  typedef struct packed {
    logic                         error;
    seen_t                        seen;
    logic [7:0]                   type_char;
    logic                         type_too_long;
    value_t [NUM_NUMERIC-1:0]     store;
  } snapshot_t;

  function automatic tag_hit_t tag_bit(input tag_t tag);
    tag_hit_t r;
    r = '0;
    for (int i = 0; i < NUM_TRACKED; i++) begin
      if (!r.hit && tag == TRACKED_TAGS[i]) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic slot_hit_t numeric_slot(input tag_t tag);
    slot_hit_t r;
    r = '0;
    for (int i = 0; i < NUM_NUMERIC; i++) begin
      if (!r.hit && tag == NUMERIC_TAGS[i]) begin
        r.hit = 1'b1;
        r.idx = 3'(i);
      end
    end
    return r;
  endfunction

  // Keep the low 31 bits of a stored value, zero-extending narrow ones
  function automatic out_value_t to_out(input value_t v);
    logic [ACC_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

endpackage

/* rtl/fmv_if.sv */
// Request channel interfaces for message bytes in and verdicts out.
interface fmv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       end_of_message;

  modport source(output valid, output msg_byte, output end_of_message, input ready);
  modport sink(input valid, input msg_byte, input end_of_message, output ready);
endinterface

interface fmv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [7:0]  message_type;
  logic [30:0] heartbeat_secs;
  logic [1:0]  order_side;
  logic [1:0]  order_kind;
  logic [30:0] limit_price;
  logic [30:0] order_quantity;

  modport source(output valid, output verdict, output message_type, output heartbeat_secs,
                 output order_side, output order_kind, output limit_price,
                 output order_quantity, input ready);
  modport sink(input valid, input verdict, input message_type, input heartbeat_secs,
               input order_side, input order_kind, input limit_price,
               input order_quantity, output ready);
endinterface

/* rtl/fmv_field_parser.sv */
// Byte input register and tag=value field parser, emitting a snapshot per message.
module fmv_field_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          field_delimiter,
  fmv_in_if.sink              in_chan,
  output logic                snap_valid,
  input  logic                snap_ready,
  output fmv_pkg::snapshot_t  snap
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eom;
  logic       consume;

  // Parse state
  logic                                         in_value;
  logic                                         in_value_next;
  fmv_pkg::tag_t                                tag_acc;
  fmv_pkg::tag_t                                tag_acc_next;
  logic                                         tag_digit;
  logic                                         tag_digit_next;
  logic                                         tag_err;
  logic                                         tag_err_next;
  logic                                         error;
  logic                                         error_next;
  fmv_pkg::seen_t                               seen;
  fmv_pkg::seen_t                               seen_next;
  fmv_pkg::value_t                              val_acc;
  fmv_pkg::value_t                              val_acc_next;
  fmv_pkg::value_status_t                       val_st;
  fmv_pkg::value_status_t                       val_st_next;
  logic [7:0]                                   type_char;
  logic [7:0]                                   type_char_next;
  logic                                         type_too_long;
  logic                                         type_too_long_next;
  fmv_pkg::value_t [fmv_pkg::NUM_NUMERIC-1:0]   store;
  fmv_pkg::value_t [fmv_pkg::NUM_NUMERIC-1:0]   store_next;

  logic                           is_digit;
  logic                           is_blank;
  logic                           tag_ok;
  logic                           good;
  logic [fmv_pkg::TAG_W+3:0]      tag_sum;
  logic [fmv_pkg::ACC_W+3:0]      val_sum;
  fmv_pkg::tag_hit_t              bit_hit;
  fmv_pkg::slot_hit_t             slot_hit;

  assign consume       = in_valid && (!in_eom || !snap_valid || snap_ready);
  assign in_chan.ready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      in_byte <= in_chan.msg_byte;
      in_eom  <= in_chan.end_of_message;
    end
  end

  assign is_digit = (in_byte >= fmv_pkg::CH_ZERO) && (in_byte <= fmv_pkg::CH_NINE);
  assign is_blank = (in_byte == fmv_pkg::CH_SPACE) ||
                    ((in_byte >= fmv_pkg::CH_TAB) && (in_byte <= fmv_pkg::CH_CR));
  assign tag_ok   = tag_digit && !tag_err;
  assign good     = ((val_st.phase == fmv_pkg::PH_DIGITS) ||
                     (val_st.phase == fmv_pkg::PH_STOPPED)) &&
                    !val_st.neg && !val_st.bad && (val_acc != '0);
  assign tag_sum  = ({4'b0, tag_acc} << 3) + ({4'b0, tag_acc} << 1) +
                    (fmv_pkg::TAG_W+4)'(in_byte[3:0]);
  assign val_sum  = ({4'b0, val_acc} << 3) + ({4'b0, val_acc} << 1) +
                    (fmv_pkg::ACC_W+4)'(in_byte[3:0]);
  assign bit_hit  = fmv_pkg::tag_bit(tag_acc);
  assign slot_hit = fmv_pkg::numeric_slot(tag_acc);

  always_comb begin
    in_value_next      = in_value;
    tag_acc_next       = tag_acc;
    tag_digit_next     = tag_digit;
    tag_err_next       = tag_err;
    error_next         = error;
    seen_next          = seen;
    val_acc_next       = val_acc;
    val_st_next        = val_st;
    type_char_next     = type_char;
    type_too_long_next = type_too_long;
    store_next         = store;

    if (!error) begin
      priority if (in_byte == field_delimiter) begin
        if (!in_value || !tag_ok) begin
          error_next = 1'b1;
        end else begin
          if (bit_hit.hit && !seen[bit_hit.idx]) begin
            seen_next[bit_hit.idx] = 1'b1;
            if (slot_hit.hit) begin
              store_next[slot_hit.idx] = good ? val_acc : '0;
            end
          end
          in_value_next  = 1'b0;
          tag_acc_next   = '0;
          tag_digit_next = 1'b0;
          tag_err_next   = 1'b0;
          val_acc_next   = '0;
          val_st_next    = '0;
        end
      end else if (in_value) begin
        // First message type field: keep a single nonzero character
        if (tag_ok && tag_acc == fmv_pkg::TAG_MSG_TYPE && !seen[fmv_pkg::BIT_TYPE]) begin
          if (type_char == 8'h00 && !type_too_long) begin
            if (in_byte == 8'h00) type_too_long_next = 1'b1;
            else                  type_char_next     = in_byte;
          end else begin
            type_too_long_next = 1'b1;
          end
        end
        if (val_st.phase != fmv_pkg::PH_STOPPED) begin
          priority if (is_digit) begin
            val_st_next.phase = fmv_pkg::PH_DIGITS;
            if (!val_st.bad) begin
              if (val_sum[fmv_pkg::ACC_W+3:fmv_pkg::ACC_W] != '0) val_st_next.bad = 1'b1;
              else val_acc_next = val_sum[fmv_pkg::ACC_W-1:0];
            end
          end else if (val_st.phase == fmv_pkg::PH_BLANK && is_blank) begin
            val_st_next = val_st;
          end else if (val_st.phase == fmv_pkg::PH_BLANK && in_byte == fmv_pkg::CH_PLUS) begin
            val_st_next.phase = fmv_pkg::PH_SIGN;
          end else if (val_st.phase == fmv_pkg::PH_BLANK && in_byte == fmv_pkg::CH_MINUS) begin
            val_st_next.phase = fmv_pkg::PH_SIGN;
            val_st_next.neg   = 1'b1;
          end else if (val_st.phase == fmv_pkg::PH_DIGITS) begin
            val_st_next.phase = fmv_pkg::PH_STOPPED;
          end else begin
            val_st_next.phase = fmv_pkg::PH_STOPPED;
            val_st_next.bad   = 1'b1;
          end
        end
      end else if (in_byte == fmv_pkg::CH_EQUALS) begin
        in_value_next = 1'b1;
      end else if (is_digit && !tag_err) begin
        tag_digit_next = 1'b1;
        if (tag_sum[fmv_pkg::TAG_W+3:fmv_pkg::TAG_W] != '0) tag_err_next = 1'b1;
        else tag_acc_next = tag_sum[fmv_pkg::TAG_W-1:0];
      end else begin
        tag_err_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value      <= 1'b0;
      tag_acc       <= '0;
      tag_digit     <= 1'b0;
      tag_err       <= 1'b0;
      error         <= 1'b0;
      seen          <= '0;
      val_acc       <= '0;
      val_st        <= '0;
      type_char     <= '0;
      type_too_long <= 1'b0;
      store         <= '0;
    end else if (consume) begin
      if (in_eom) begin
        in_value      <= 1'b0;
        tag_acc       <= '0;
        tag_digit     <= 1'b0;
        tag_err       <= 1'b0;
        error         <= 1'b0;
        seen          <= '0;
        val_acc       <= '0;
        val_st        <= '0;
        type_char     <= '0;
        type_too_long <= 1'b0;
        store         <= '0;
      end else begin
        in_value      <= in_value_next;
        tag_acc       <= tag_acc_next;
        tag_digit     <= tag_digit_next;
        tag_err       <= tag_err_next;
        error         <= error_next;
        seen          <= seen_next;
        val_acc       <= val_acc_next;
        val_st        <= val_st_next;
        type_char     <= type_char_next;
        type_too_long <= type_too_long_next;
        store         <= store_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (consume && in_eom) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (consume && in_eom) begin
      snap.error         <= error_next;
      snap.seen          <= seen_next;
      snap.type_char     <= type_char_next;
      snap.type_too_long <= type_too_long_next;
      snap.store         <= store_next;
    end
  end

endmodule

/* rtl/fmv_judge.sv */
// Verdict checks over a finished message and the result output register.
module fmv_judge (
  input  logic                clk,
  input  logic                rst,
  input  logic                snap_valid,
  output logic                snap_ready,
  input  fmv_pkg::snapshot_t  snap,
  fmv_out_if.source           out_chan
);

  logic                 out_valid;
  logic                 one;
  logic                 is_d;
  fmv_pkg::verdict_t    verdict;
  fmv_pkg::value_t      hb;
  fmv_pkg::value_t      side;
  fmv_pkg::value_t      kind;
  fmv_pkg::value_t      price;
  fmv_pkg::value_t      qty;
  logic                 ok;

  logic [3:0]           r_verdict;
  logic [7:0]           r_type;
  fmv_pkg::out_value_t  r_hb;
  logic [1:0]           r_side;
  logic [1:0]           r_kind;
  fmv_pkg::out_value_t  r_price;
  fmv_pkg::out_value_t  r_qty;

  assign hb    = snap.store[fmv_pkg::SLOT_HB];
  assign side  = snap.store[fmv_pkg::SLOT_SIDE];
  assign kind  = snap.store[fmv_pkg::SLOT_KIND];
  assign price = snap.store[fmv_pkg::SLOT_PRICE];
  assign qty   = snap.store[fmv_pkg::SLOT_QTY];
  assign one   = (snap.type_char != 8'h00) && !snap.type_too_long;

  always_comb begin
    is_d = 1'b0;
    priority if (snap.error) begin
      verdict = fmv_pkg::V_MALFORMED;
    end else if ((snap.seen & fmv_pkg::HEADER_MASK) != fmv_pkg::HEADER_MASK) begin
      verdict = fmv_pkg::V_NO_HEADER;
    end else if (one && snap.type_char == fmv_pkg::TYPE_LOGON) begin
      priority if (!snap.seen[fmv_pkg::BIT_HB]) verdict = fmv_pkg::V_NO_HB;
      else if (hb == '0)                         verdict = fmv_pkg::V_BAD_HB;
      else                                       verdict = fmv_pkg::V_OK;
    end else if (one && snap.type_char == fmv_pkg::TYPE_NEW_ORDER) begin
      priority if ((snap.seen & fmv_pkg::ORDER_MASK) != fmv_pkg::ORDER_MASK) begin
        verdict = fmv_pkg::V_NO_ORDER;
      end else if (side != fmv_pkg::VAL_ONE && side != fmv_pkg::VAL_TWO) begin
        verdict = fmv_pkg::V_BAD_SIDE;
      end else if (kind != fmv_pkg::VAL_ONE && kind != fmv_pkg::VAL_TWO) begin
        verdict = fmv_pkg::V_BAD_KIND;
      end else if (kind == fmv_pkg::VAL_TWO && !snap.seen[fmv_pkg::BIT_PRICE]) begin
        verdict = fmv_pkg::V_NO_PRICE;
      end else if (kind == fmv_pkg::VAL_TWO && price == '0) begin
        verdict = fmv_pkg::V_BAD_PRICE;
      end else if (qty == '0) begin
        verdict = fmv_pkg::V_BAD_QTY;
      end else begin
        verdict = fmv_pkg::V_OK;
        is_d    = 1'b1;
      end
    end else begin
      verdict = fmv_pkg::V_UNSUPPORTED;
    end
  end

  assign ok         = (verdict == fmv_pkg::V_OK);
  assign snap_ready = !out_valid || out_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
    if (snap_valid && snap_ready) begin
      r_verdict <= verdict;
      r_type    <= (one && snap.seen[fmv_pkg::BIT_TYPE]) ? snap.type_char : 8'h00;
      r_hb      <= (ok && snap.seen[fmv_pkg::BIT_HB]) ? fmv_pkg::to_out(hb) : '0;
      r_side    <= (ok && is_d) ? side[1:0] : 2'b00;
      r_kind    <= (ok && is_d) ? kind[1:0] : 2'b00;
      r_price   <= (ok && is_d && kind == fmv_pkg::VAL_TWO) ? fmv_pkg::to_out(price) : '0;
      r_qty     <= (ok && is_d) ? fmv_pkg::to_out(qty) : '0;
    end
  end

  assign out_chan.valid          = out_valid;
  assign out_chan.verdict        = r_verdict;
  assign out_chan.message_type   = r_type;
  assign out_chan.heartbeat_secs = r_hb;
  assign out_chan.order_side     = r_side;
  assign out_chan.order_kind     = r_kind;
  assign out_chan.limit_price    = r_price;
  assign out_chan.order_quantity = r_qty;

endmodule

/* rtl/fix_message_validator_core.sv */
// Top level of the FIX tag=value message validator.
// Path: a final byte passes the input register and the snapshot register; its result is held in the output register.
// Throughput: one byte request per cycle; the per-byte field update is one add and
// compare on the tag or value accumulator, closed between input register and parse state.
// Bytes that do not end a message pass without waiting on the output side.
// Reset: synchronous; clears all parse state, the pipeline valids and sets the delimiter to SOH.
module fix_message_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  fmv_in_if.sink     in_chan,
  fmv_out_if.source  out_chan
);

  // Field delimiter register; the user must write it only while idle, the block does not enforce this
  logic [7:0] field_delimiter;

  // Handover of a finished message from the parser to the verdict stage
  logic               snap_valid;
  logic               snap_ready;
  fmv_pkg::snapshot_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_delimiter <= fmv_pkg::DELIM_RESET;
    end else if (cfg_write) begin
      field_delimiter <= cfg_data;
    end
  end

  // Register each byte request, advance the field parser, and on the final
  // byte hand the message state over and clear it for the next message.
  fmv_field_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .field_delimiter (field_delimiter),
    .in_chan         (in_chan),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap            (snap)
  );

  // Run the verdict checks in order and hold the result until it is taken.
  fmv_judge u_judge (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_chan   (out_chan)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the FIX message validator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmv_pkg::*;

  // Message shapes the stimulus builds
  localparam int FORM_LOGON = 0;
  localparam int FORM_ORDER = 1;
  localparam int FORM_OTHER = 2;

  // Order type codes carried in tag 40
  localparam int KIND_MARKET = 1;
  localparam int KIND_LIMIT  = 2;

  localparam logic [34:0] TAG_CAP   = 35'h7FFF_FFFF;
  localparam logic [34:0] VALUE_CAP = 35'((64'd1 << (VALUE_BITS - 1)) - 1);

  typedef struct packed {
    logic [3:0] verdict;
    logic [7:0] message_type;
    out_value_t heartbeat;
    logic [1:0] side;
    logic [1:0] kind;
    out_value_t price;
    out_value_t quantity;
  } verdict_rec_t;

  // Predicts the verdict of every message and checks the block's results in order
  class fix_verdict_model;
    logic [7:0]     delimiter;
    bit             in_value;
    tag_t           tag_acc;
    bit             tag_digit;
    bit             tag_bad;
    bit             parse_err;
    seen_t          seen;
    value_t         value_acc;
    phase_t         vphase;
    bit             vneg;
    bit             vbad;
    logic [7:0]     type_char;
    bit             type_long;
    value_t         store [NUM_NUMERIC];
    verdict_rec_t   pending [$];
    int unsigned    checked;
    int unsigned    failures;

    function new();
      delimiter = DELIM_RESET;
      clear_message();
    endfunction

    function void clear_field();
      in_value  = 1'b0;
      tag_acc   = '0;
      tag_digit = 1'b0;
      tag_bad   = 1'b0;
      value_acc = '0;
      vphase    = PH_BLANK;
      vneg      = 1'b0;
      vbad      = 1'b0;
    endfunction

    function void clear_message();
      clear_field();
      parse_err = 1'b0;
      seen      = '0;
      type_char = '0;
      type_long = 1'b0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function bit tag_good();
      return tag_digit && !tag_bad;
    endfunction

    function int tracked_pos(tag_t t);
      case (t)
        31'd8:   return 0;
        31'd9:   return 1;
        31'd35:  return BIT_TYPE;
        31'd34:  return 3;
        31'd49:  return 4;
        31'd56:  return 5;
        31'd10:  return 6;
        31'd11:  return 7;
        31'd55:  return 8;
        31'd54:  return 9;
        31'd38:  return 10;
        31'd40:  return 11;
        31'd108: return BIT_HB;
        31'd44:  return BIT_PRICE;
        default: return -1;
      endcase
    endfunction

    function int numeric_pos(tag_t t);
      case (t)
        31'd108: return SLOT_HB;
        31'd54:  return SLOT_SIDE;
        31'd40:  return SLOT_KIND;
        31'd44:  return SLOT_PRICE;
        31'd38:  return SLOT_QTY;
        default: return -1;
      endcase
    endfunction

    function logic [34:0] grow(logic [30:0] acc, logic [7:0] ch);
      return 35'(acc) * 35'd10 + 35'(ch - CH_ZERO);
    endfunction

    // Note one accepted request; the final byte of a message yields a verdict
    function void absorb_byte(logic [7:0] b, bit eom);
      logic [34:0]  grown;
      int           pos;
      int           slot;
      bit           single;
      bit           is_d;
      verdict_t     v;
      verdict_rec_t r;
      if (!parse_err) begin
        if (b == delimiter) begin
          if (!in_value || !tag_good()) begin
            parse_err = 1'b1;
          end else begin
            pos = tracked_pos(tag_acc);
            if (pos >= 0 && !seen[pos]) begin
              seen[pos] = 1'b1;
              slot = numeric_pos(tag_acc);
              if (slot >= 0)
                store[slot] = (vphase >= PH_DIGITS && !vneg && !vbad && value_acc != 0) ?
                              value_acc : '0;
            end
            clear_field();
          end
        end else if (in_value) begin
          if (tag_good() && tag_acc == TAG_MSG_TYPE && !seen[BIT_TYPE]) begin
            if (type_char == 0 && !type_long) begin
              if (b == 8'h00) type_long = 1'b1;
              else type_char = b;
            end else begin
              type_long = 1'b1;
            end
          end
          if (vphase != PH_STOPPED) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              vphase = PH_DIGITS;
              if (!vbad) begin
                grown = grow(value_acc, b);
                if (grown > VALUE_CAP) vbad = 1'b1;
                else value_acc = grown[ACC_W-1:0];
              end
            end else if (vphase == PH_BLANK && (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
              // leading blank: skip
            end else if (vphase == PH_BLANK && b == CH_PLUS) begin
              vphase = PH_SIGN;
            end else if (vphase == PH_BLANK && b == CH_MINUS) begin
              vphase = PH_SIGN;
              vneg   = 1'b1;
            end else if (vphase == PH_DIGITS) begin
              vphase = PH_STOPPED;
            end else begin
              vphase = PH_STOPPED;
              vbad   = 1'b1;
            end
          end
        end else if (b == CH_EQUALS) begin
          in_value = 1'b1;
        end else if (b >= CH_ZERO && b <= CH_NINE && !tag_bad) begin
          tag_digit = 1'b1;
          grown = grow(tag_acc, b);
          if (grown > TAG_CAP) tag_bad = 1'b1;
          else tag_acc = grown[TAG_W-1:0];
        end else begin
          tag_bad = 1'b1;
        end
      end
      if (!eom) return;

      single = type_char != 0 && !type_long;
      is_d   = 1'b0;
      if (parse_err) begin
        v = V_MALFORMED;
      end else if ((seen & HEADER_MASK) != HEADER_MASK) begin
        v = V_NO_HEADER;
      end else if (single && type_char == TYPE_LOGON) begin
        if (!seen[BIT_HB]) v = V_NO_HB;
        else if (store[SLOT_HB] == 0) v = V_BAD_HB;
        else v = V_OK;
      end else if (single && type_char == TYPE_NEW_ORDER) begin
        if ((seen & ORDER_MASK) != ORDER_MASK) v = V_NO_ORDER;
        else if (store[SLOT_SIDE] != 1 && store[SLOT_SIDE] != 2) v = V_BAD_SIDE;
        else if (store[SLOT_KIND] != 1 && store[SLOT_KIND] != 2) v = V_BAD_KIND;
        else if (store[SLOT_KIND] == 2 && !seen[BIT_PRICE]) v = V_NO_PRICE;
        else if (store[SLOT_KIND] == 2 && store[SLOT_PRICE] == 0) v = V_BAD_PRICE;
        else if (store[SLOT_QTY] == 0) v = V_BAD_QTY;
        else begin
          v    = V_OK;
          is_d = 1'b1;
        end
      end else begin
        v = V_UNSUPPORTED;
      end

      r.verdict      = v;
      r.message_type = (single && seen[BIT_TYPE]) ? type_char : 8'h00;
      r.heartbeat    = (v == V_OK && seen[BIT_HB]) ? store[SLOT_HB] : '0;
      r.side         = (v == V_OK && is_d) ? store[SLOT_SIDE][1:0] : 2'd0;
      r.kind         = (v == V_OK && is_d) ? store[SLOT_KIND][1:0] : 2'd0;
      r.price        = (v == V_OK && is_d && store[SLOT_KIND] == 2) ? store[SLOT_PRICE] : '0;
      r.quantity     = (v == V_OK && is_d) ? store[SLOT_QTY] : '0;
      pending.insert(pending.size(), r);
      clear_message();
    endfunction

    function void match_field(string name, logic [30:0] want, logic [30:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    // Check one accepted result against the oldest predicted verdict
    function void compare_verdict(verdict_rec_t got);
      verdict_rec_t want;
      if (pending.size() == 0) begin
        $error("verdict %0d arrived with no message outstanding", got.verdict);
        failures++;
        return;
      end
      want = pending.pop_front();
      checked++;
      match_field("verdict", want.verdict, got.verdict);
      match_field("message_type", want.message_type, got.message_type);
      match_field("heartbeat_secs", want.heartbeat, got.heartbeat);
      match_field("order_side", want.side, got.side);
      match_field("order_kind", want.kind, got.kind);
      match_field("limit_price", want.price, got.price);
      match_field("order_quantity", want.quantity, got.quantity);
    endfunction
  endclass

  typedef struct {
    string tag;
    string val;
    bit    has_eq;
    bit    nul_val;
  } fix_field_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;

  fmv_in_if  in_chan ();
  fmv_out_if out_chan ();

  fix_message_validator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  fix_verdict_model tracker;
  fix_field_t       fields [$];
  string            tail;
  logic [7:0]       wire_bytes [$];
  logic [7:0]       delim_now = DELIM_RESET;
  bit               src_idle_on;
  bit               sink_idle_on;
  int unsigned      hold_left;
  int unsigned      bytes_sent;
  int unsigned      settings_used = 1;

  // ---------------------------------------------------------------------------
  // Message composition. A message is planned as a list of tag=value fields,
  // optionally roughened, then flattened to bytes with the current delimiter.
  // ---------------------------------------------------------------------------

  function automatic void add_field(string t, string v);
    fix_field_t f;
    f.tag     = t;
    f.val     = v;
    f.has_eq  = 1'b1;
    f.nul_val = 1'b0;
    fields.insert(fields.size(), f);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    wire_bytes.insert(wire_bytes.size(), b);
  endfunction

  // Overwrite the first field carrying this tag, or append one
  function automatic void set_value(string t, string v);
    foreach (fields[i]) begin
      if (fields[i].tag == t) begin
        fields[i].val = v;
        return;
      end
    end
    add_field(t, v);
  endfunction

  function automatic void drop_tag(string t);
    foreach (fields[i]) begin
      if (fields[i].tag == t) begin
        fields.delete(i);
        return;
      end
    end
  endfunction

  // Positive value with a random number of digits, never above 2^31-1
  function automatic string good_number();
    int unsigned n;
    n = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
    if (n == 0) n = 1;
    return $sformatf("%0d", n);
  endfunction

  // Values that stress the integer conversion: zero, limits, signs, blanks, junk
  function automatic string rough_number();
    case ($urandom_range(0, 11))
      0:       return "0";
      1:       return "2147483647";
      2:       return "2147483648";
      3:       return "99999999999";
      4:       return {"-", good_number()};
      5:       return {"+", good_number()};
      6:       return {" \t", good_number()};
      7:       return {good_number(), "x9"};
      8:       return "";
      9:       return "+-5";
      10:      return {"000", good_number()};
      default: return $sformatf("%0d", $urandom_range(0, 3));
    endcase
  endfunction

  function automatic string odd_type();
    string s;
    s = "?";
    case ($urandom_range(0, 5))
      0:       return "0";
      1:       return "5";
      2:       return "AB";
      3:       return "";
      4:       return "a";
      default: begin
        s[0] = 8'($urandom_range(33, 126));
        return s;
      end
    endcase
  endfunction

  // Plan a well-formed message of the given shape with short random content
  function automatic void plan_message(int form, int kind_code);
    fields.delete();
    tail = "";
    add_field("8", "FIX");
    add_field("9", $sformatf("%0d", $urandom_range(10, 99)));
    case (form)
      FORM_LOGON: add_field("35", "A");
      FORM_ORDER: add_field("35", "D");
      default:    add_field("35", odd_type());
    endcase
    add_field("49", "B");
    add_field("56", "V");
    add_field("34", $sformatf("%0d", $urandom_range(1, 99)));
    if (form == FORM_LOGON)
      add_field("108", $sformatf("%0d", $urandom_range(1, 300)));
    if (form == FORM_ORDER) begin
      add_field("11", $sformatf("%0d", $urandom_range(1, 99)));
      add_field("55", "X");
      add_field("54", $sformatf("%0d", $urandom_range(1, 2)));
      add_field("38", good_number());
      add_field("40", $sformatf("%0d", kind_code));
      if (kind_code == KIND_LIMIT || $urandom_range(0, 3) == 0)
        add_field("44", good_number());
    end
    add_field("10", $sformatf("%0d", $urandom_range(0, 9)));
  endfunction

  // Break a planned message in one to three random ways
  function automatic void roughen_message();
    int         pos;
    fix_field_t f;
    repeat ($urandom_range(1, 3)) begin
      pos = (fields.size() == 0) ? 0 : $urandom_range(0, fields.size() - 1);
      case ($urandom_range(0, 7))
        0: if (fields.size() > 0) fields.delete(pos);
        1: if (fields.size() > 0) begin
          f = fields[pos];
          f.val = rough_number();
          fields.insert(pos + 1, f);
        end
        2: if (fields.size() > 1) begin
          f = fields[pos];
          fields[pos] = fields[0];
          fields[0] = f;
        end
        3: case ($urandom_range(0, 3))
          0:       add_field("52", good_number());
          1:       add_field("2147483647", "x");
          2:       add_field("0", "1");
          default: add_field("0035", "D");
        endcase
        4: if (fields.size() > 0) begin
          case ($urandom_range(0, 3))
            0:       fields[pos].tag = "4x";
            1:       fields[pos].tag = "";
            2:       fields[pos].tag = "2147483648";
            default: fields[pos].has_eq = 1'b0;
          endcase
        end
        5: if (fields.size() > 0) fields[pos].val = rough_number();
        6: tail = ($urandom_range(0, 1) == 0) ? "58=hi" : good_number();
        default: if (fields.size() > 0) fields[pos].nul_val = 1'b1;
      endcase
    end
  endfunction

  function automatic void render_message();
    wire_bytes.delete();
    foreach (fields[i]) begin
      for (int c = 0; c < fields[i].tag.len(); c++) put_byte(fields[i].tag[c]);
      if (fields[i].has_eq) put_byte(CH_EQUALS);
      if (fields[i].nul_val) put_byte(8'h00);
      for (int c = 0; c < fields[i].val.len(); c++) put_byte(fields[i].val[c]);
      put_byte(delim_now);
    end
    for (int c = 0; c < tail.len(); c++) put_byte(tail[c]);
    if (wire_bytes.size() == 0) put_byte(delim_now);
  endfunction

  // Random bytes laced with delimiters, equals signs and digits
  function automatic void plan_noise(int longest);
    wire_bytes.delete();
    repeat ($urandom_range(1, longest)) begin
      case ($urandom_range(0, 3))
        0:       put_byte(delim_now);
        1:       put_byte(CH_EQUALS);
        2:       put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        default: put_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte request and hold it until the block accepts it
  task automatic send_byte(logic [7:0] b, bit eom);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.msg_byte       <= b;
    in_chan.end_of_message <= eom;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    tracker.absorb_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (wire_bytes[i]) send_byte(wire_bytes[i], i == wire_bytes.size() - 1);
  endtask

  // Drain the block, let its pipeline settle, then write the delimiter
  task automatic change_delimiter(logic [7:0] d);
    in_chan.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.delimiter = d;
    delim_now = d;
    settings_used++;
  endtask

  // Mostly well-formed messages with random content, some broken, some noise
  task automatic run_random(int count, bit churn);
    int pick;
    repeat (count) begin
      if (churn && $urandom_range(0, 7) == 0) begin
        src_idle_on  = $urandom_range(0, 1);
        sink_idle_on = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        plan_noise(16);
      end else begin
        if (pick < 7) plan_message(FORM_LOGON, 0);
        else if (pick < 16) plan_message(FORM_ORDER, $urandom_range(KIND_MARKET, KIND_LIMIT));
        else plan_message(FORM_OTHER, 0);
        if ($urandom_range(0, 9) < 3) roughen_message();
        render_message();
      end
      send_message();
    end
  endtask

  // Corner messages: limits of the heartbeat field, every verdict, the malformed
  // tag forms, a repeated tag, a zero type byte and an unterminated tail
  task automatic run_directed();
    for (int d = 0; d < 23; d++) begin
      case (d)
        0:  plan_message(FORM_LOGON, 0);
        1:  plan_message(FORM_ORDER, KIND_LIMIT);
        2:  begin plan_message(FORM_LOGON, 0); drop_tag("108"); end
        3:  begin plan_message(FORM_LOGON, 0); set_value("108", "0"); end
        4:  begin plan_message(FORM_LOGON, 0); set_value("108", "2147483647"); end
        5:  begin plan_message(FORM_LOGON, 0); set_value("108", "2147483648"); end
        6:  begin plan_message(FORM_LOGON, 0); set_value("108", " \t+045xyz"); end
        7:  begin plan_message(FORM_ORDER, KIND_MARKET); drop_tag("54"); end
        8:  begin plan_message(FORM_ORDER, KIND_MARKET); set_value("54", "3"); end
        9:  begin plan_message(FORM_ORDER, KIND_MARKET); set_value("40", "3"); end
        10: begin plan_message(FORM_ORDER, KIND_LIMIT); drop_tag("44"); end
        11: begin plan_message(FORM_ORDER, KIND_LIMIT); set_value("44", "-7"); end
        12: begin plan_message(FORM_ORDER, KIND_MARKET); set_value("38", "0"); end
        13: begin plan_message(FORM_OTHER, 0); set_value("35", "X"); end
        14: begin
          plan_message(FORM_LOGON, 0);
          set_value("35", "");
          fields[2].nul_val = 1'b1;
        end
        15: begin plan_message(FORM_LOGON, 0); add_field("4a", "1"); end
        16: begin
          fields.delete();
          tail = "";
          add_field("58", "x");
          fields[0].has_eq = 1'b0;
        end
        17: begin fields.delete(); tail = ""; add_field("", "5"); end
        18: begin fields.delete(); tail = ""; add_field("2147483648", "5"); end
        19: begin plan_message(FORM_ORDER, KIND_MARKET); add_field("54", "7"); end
        20: begin plan_message(FORM_LOGON, 0); drop_tag("49"); end
        21: begin fields.delete(); tail = ""; end
        default: begin
          plan_message(FORM_LOGON, 0);
          drop_tag("108");
          tail = "108=5";
        end
      endcase
      render_message();
      send_message();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls in random bursts, or holds off entirely
  // while hold_left counts down; every accepted result is checked.
  // ---------------------------------------------------------------------------

  initial begin : result_receiver
    int unsigned gap;
    gap = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_chan.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 5);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_checker
    verdict_rec_t got;
    if (rst === 1'b0 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.verdict      = out_chan.verdict;
      got.message_type = out_chan.message_type;
      got.heartbeat    = out_chan.heartbeat_secs;
      got.side         = out_chan.order_side;
      got.kind         = out_chan.order_kind;
      got.price        = out_chan.limit_price;
      got.quantity     = out_chan.order_quantity;
      tracker.compare_verdict(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    tracker      = new();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_left    = 0;
    bytes_sent   = 0;
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_data               <= 8'h00;
    in_chan.valid          <= 1'b0;
    in_chan.msg_byte       <= 8'h00;
    in_chan.end_of_message <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset delimiter first, so the power-on value is exercised untouched
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    run_directed();
    run_random(2, 1'b1);

    // Extremes of the delimiter byte
    change_delimiter(8'h00);
    run_random(1, 1'b1);
    change_delimiter(8'hFF);
    run_random(1, 1'b1);

    // Printable delimiter; stall the output for a long stretch while short
    // messages keep arriving, so results back up and the input stalls
    change_delimiter("|");
    run_random(1, 1'b1);
    src_idle_on = 1'b0;
    hold_left   = 300;
    repeat (30) begin
      plan_noise(3);
      send_message();
    end
    src_idle_on = 1'b1;
    run_random(1, 1'b1);

    // Delimiter equal to the equals sign makes every field malformed
    change_delimiter(CH_EQUALS);
    run_random(1, 1'b1);
    change_delimiter(8'($urandom_range(0, 255)));
    run_random(1, 1'b1);

    // Back to SOH at full rate on both sides
    change_delimiter(DELIM_RESET);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_random(3, 1'b0);

    in_chan.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d verdicts from %0d message bytes over %0d delimiter settings.",
             tracker.checked, bytes_sent, settings_used);
    $display("Traffic mixed corner messages, broken and noisy input and a long output stall.");
    if (tracker.failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard: several times the slowest legal run
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/fmv_pkg.sv
rtl/fmv_if.sv
rtl/fmv_field_parser.sv
rtl/fmv_judge.sv
rtl/fix_message_validator_core.sv
verif/tb_top.sv
